// File: design/inertia_tensor_accumulator_assert.svh
// ----------------------------------------------------------------------------
// inertia tensor accumulator assertion macros
// shared concurrent assertion forms used by the controller and the datapath
// ----------------------------------------------------------------------------
`ifndef INERTIA_TENSOR_ACCUMULATOR_ASSERT_SVH
`define INERTIA_TENSOR_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define ITA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ITA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// types, constants and element mapping for the inertia tensor accumulator
// ----------------------------------------------------------------------------
package ita_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int MASS_BITS_DEF  = 16;

   localparam int SUM_W        = 64;
   localparam int SUM_COUNT    = 6;
   localparam int TENSOR_ELEMS = 9;
   localparam int IDX_W        = 4;

   localparam logic [SUM_W-1:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [SUM_W-1:0] SUM_MIN = 64'h8000_0000_0000_0000;

   // pairwise coordinate products
   typedef enum logic [2:0] {
      PROD_XX, PROD_YY, PROD_ZZ, PROD_XY, PROD_XZ, PROD_YZ
   } prod_type;

   // running sums: three diagonal (about x, y, z) then three off-diagonal
   typedef enum logic [2:0] {
      TERM_XX, TERM_YY, TERM_ZZ, TERM_XY, TERM_XZ, TERM_YZ
   } term_type;

   // steps of one term through the shared multiplier
   typedef enum logic [2:0] {
      STEP_SEL, STEP_LO, STEP_HI, STEP_SAT, STEP_ACC
   } step_type;

   typedef struct packed {
      logic               capture;
      logic               prod_en;
      prod_type           prod_sel;
      logic               term_en;
      step_type           step;
      term_type           term_sel;
      logic               emit_en;
      logic [IDX_W-1:0]   emit_idx;
   } cmd_type;

   typedef struct packed {
      logic ghost;
      logic last;
      logic out_free;
   } sts_type;

   // which running sum a row-major tensor element reads
   function automatic term_type elem_src(input logic [IDX_W-1:0] idx);
      case (idx)
         4'd0:    elem_src = TERM_XX;
         4'd1:    elem_src = TERM_XY;
         4'd2:    elem_src = TERM_XZ;
         4'd3:    elem_src = TERM_XY;
         4'd4:    elem_src = TERM_YY;
         4'd5:    elem_src = TERM_YZ;
         4'd6:    elem_src = TERM_XZ;
         4'd7:    elem_src = TERM_YZ;
         4'd8:    elem_src = TERM_ZZ;
         default: elem_src = TERM_XX;
      endcase
   endfunction

endpackage

// File: design/ita_if.sv
// ----------------------------------------------------------------------------
// ita channel interfaces
// valid/ready channels for cell items and tensor element items
// ----------------------------------------------------------------------------
interface ita_req_if #(
   parameter int COORD_BITS = ita_pkg::COORD_BITS_DEF,
   parameter int MASS_BITS  = ita_pkg::MASS_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic signed [COORD_BITS-1:0] center_z;
   logic [MASS_BITS-1:0]         cell_mass;
   logic                         ghost_cell;
   logic                         first_cell;
   logic                         last_cell;

   modport source (
      output valid, center_x, center_y, center_z, cell_mass,
             ghost_cell, first_cell, last_cell,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, center_z, cell_mass,
             ghost_cell, first_cell, last_cell,
      output ready
   );
endinterface

interface ita_rsp_if ();
   logic                              valid;
   logic                              ready;
   logic [ita_pkg::IDX_W-1:0]         element_index;
   logic signed [ita_pkg::SUM_W-1:0]  element_value;
   logic                              final_element;

   modport source (
      output valid, element_index, element_value, final_element,
      input  ready
   );
   modport sink (
      input  valid, element_index, element_value, final_element,
      output ready
   );
endinterface

// File: design/ita_controller.sv
// ----------------------------------------------------------------------------
// ita_controller
// sequences products, per-term multiply/saturate/accumulate and emission
// ----------------------------------------------------------------------------
`include "inertia_tensor_accumulator_assert.svh"

module ita_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output ita_pkg::cmd_type cmd,
   input  ita_pkg::sts_type sts
);

   typedef enum logic [1:0] {ST_IDLE, ST_PROD, ST_TERM, ST_EMIT} state_type;

   state_type                    state_ff, state_in;
   logic [ita_pkg::IDX_W-1:0]    cnt_ff, cnt_in;
   ita_pkg::term_type            term_ff, term_in;
   ita_pkg::step_type            step_ff, step_in;
   logic                         ready_ff, ready_in;

   localparam logic [ita_pkg::IDX_W-1:0] EMIT_LAST = 4'(ita_pkg::TENSOR_ELEMS - 1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      term_in  = term_ff;
      step_in  = step_ff;
      cmd          = '0;
      cmd.prod_sel = ita_pkg::prod_type'(cnt_ff[2:0]);
      cmd.step     = step_ff;
      cmd.term_sel = term_ff;
      cmd.emit_idx = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = ST_PROD;
               cnt_in      = '0;
            end
         end
         ST_PROD: begin
            cmd.prod_en = 1'b1;
            if (cnt_ff[2:0] == ita_pkg::PROD_YZ) begin
               cnt_in  = '0;
               term_in = ita_pkg::TERM_XX;
               step_in = ita_pkg::STEP_SEL;
               if (!sts.ghost) begin
                  state_in = ST_TERM;
               end else if (sts.last) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_TERM: begin
            cmd.term_en = 1'b1;
            unique case (step_ff)
               ita_pkg::STEP_SEL: step_in = ita_pkg::STEP_LO;
               ita_pkg::STEP_LO:  step_in = ita_pkg::STEP_HI;
               ita_pkg::STEP_HI:  step_in = ita_pkg::STEP_SAT;
               ita_pkg::STEP_SAT: step_in = ita_pkg::STEP_ACC;
               ita_pkg::STEP_ACC: begin
                  step_in = ita_pkg::STEP_SEL;
                  if (term_ff == ita_pkg::TERM_YZ) begin
                     state_in = sts.last ? ST_EMIT : ST_IDLE;
                  end else begin
                     term_in = ita_pkg::term_type'(3'(term_ff + 3'd1));
                  end
               end
               default: step_in = ita_pkg::STEP_SEL;
            endcase
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_en = 1'b1;
               if (cnt_ff == EMIT_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         term_ff  <= ita_pkg::TERM_XX;
         step_ff  <= ita_pkg::STEP_SEL;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         term_ff  <= term_in;
         step_ff  <= step_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

   `ITA_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && ready_ff, state_ff == ST_PROD && !ready_ff, "accepted item did not start products")
   `ITA_ASSERT_IMPLIES(a_ready_idle, clock, reset, ready_ff, state_ff == ST_IDLE, "ready outside idle")
   `ITA_ASSERT_NEXT(a_emit_done, clock, reset, cmd.emit_en && cnt_ff == EMIT_LAST, ready_ff && state_ff == ST_IDLE, "no return to idle after last element")

endmodule

// File: design/ita_datapath.sv
// ----------------------------------------------------------------------------
// ita_datapath
// shared multiplier, saturation, six running sums and the output register
// ----------------------------------------------------------------------------
`include "inertia_tensor_accumulator_assert.svh"

module ita_datapath #(
   parameter int COORD_BITS = ita_pkg::COORD_BITS_DEF,
   parameter int MASS_BITS  = ita_pkg::MASS_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   ita_req_if.sink          req_port,
   ita_rsp_if.source        rsp_port,
   input  ita_pkg::cmd_type cmd,
   output ita_pkg::sts_type sts
);

   localparam int C      = COORD_BITS;
   localparam int M      = MASS_BITS;
   localparam int MW     = (M > C) ? M : C;
   localparam int PW     = 2 * C;
   localparam int FULL_W = M + PW;
   localparam int EXT_W  = (FULL_W > ita_pkg::SUM_W) ? FULL_W : ita_pkg::SUM_W;
   localparam int SW     = ita_pkg::SUM_W;

   function automatic logic [C-1:0] mag_of(input logic [C-1:0] v);
      mag_of = v[C-1] ? (~v + 1'b1) : v;
   endfunction

   // captured cell
   logic [C-1:0]      mag_x_ff, mag_y_ff, mag_z_ff;
   logic              sgn_x_ff, sgn_y_ff, sgn_z_ff;
   logic [M-1:0]      mass_ff;
   logic              ghost_ff, last_ff;

   logic [PW-1:0]     prod_ff [6];
   logic [PW-1:0]     sval_ff, sval_in;
   logic              neg_ff, neg_in;
   logic [M+C-1:0]    lo_ff, hi_ff;
   logic [SW-1:0]     term_ff, term_in;
   logic [SW-1:0]     sum_ff [ita_pkg::SUM_COUNT];

   logic                        rsp_valid_ff;
   logic [ita_pkg::IDX_W-1:0]   rsp_index_ff;
   logic [SW-1:0]               rsp_value_ff;
   logic                        rsp_final_ff;

   logic [MW-1:0]     opa;
   logic [C-1:0]      opb;
   logic [MW+C-1:0]   mul_res;
   logic [FULL_W-1:0] full;
   logic [EXT_W-1:0]  full_ext;
   logic              over;
   ita_pkg::term_type rd_idx;
   logic [SW-1:0]     rd_val;
   logic [SW:0]       acc_wide;
   logic [SW-1:0]     acc_in;

   // shared multiplier operands
   always_comb begin
      opa = '0;
      opb = '0;
      if (cmd.prod_en) begin
         unique case (cmd.prod_sel)
            ita_pkg::PROD_XX: begin opa = MW'(mag_x_ff); opb = mag_x_ff; end
            ita_pkg::PROD_YY: begin opa = MW'(mag_y_ff); opb = mag_y_ff; end
            ita_pkg::PROD_ZZ: begin opa = MW'(mag_z_ff); opb = mag_z_ff; end
            ita_pkg::PROD_XY: begin opa = MW'(mag_x_ff); opb = mag_y_ff; end
            ita_pkg::PROD_XZ: begin opa = MW'(mag_x_ff); opb = mag_z_ff; end
            ita_pkg::PROD_YZ: begin opa = MW'(mag_y_ff); opb = mag_z_ff; end
            default: ;
         endcase
      end else if (cmd.term_en && cmd.step == ita_pkg::STEP_LO) begin
         opa = MW'(mass_ff);
         opb = sval_ff[C-1:0];
      end else if (cmd.term_en && cmd.step == ita_pkg::STEP_HI) begin
         opa = MW'(mass_ff);
         opb = sval_ff[PW-1:C];
      end
   end

   assign mul_res = opa * opb;

   // operand of the selected term and its sign
   always_comb begin
      sval_in = '0;
      neg_in  = 1'b0;
      unique case (cmd.term_sel)
         ita_pkg::TERM_XX: sval_in = prod_ff[ita_pkg::PROD_YY] + prod_ff[ita_pkg::PROD_ZZ];
         ita_pkg::TERM_YY: sval_in = prod_ff[ita_pkg::PROD_XX] + prod_ff[ita_pkg::PROD_ZZ];
         ita_pkg::TERM_ZZ: sval_in = prod_ff[ita_pkg::PROD_XX] + prod_ff[ita_pkg::PROD_YY];
         ita_pkg::TERM_XY: begin
            sval_in = prod_ff[ita_pkg::PROD_XY];
            neg_in  = (sgn_x_ff == sgn_y_ff);
         end
         ita_pkg::TERM_XZ: begin
            sval_in = prod_ff[ita_pkg::PROD_XZ];
            neg_in  = (sgn_x_ff == sgn_z_ff);
         end
         ita_pkg::TERM_YZ: begin
            sval_in = prod_ff[ita_pkg::PROD_YZ];
            neg_in  = (sgn_y_ff == sgn_z_ff);
         end
         default: ;
      endcase
   end

   // recombine halves and clamp the term to the 64-bit range
   always_comb begin
      full     = (FULL_W'(hi_ff) << C) + FULL_W'(lo_ff);
      full_ext = EXT_W'(full);
      over     = full_ext > EXT_W'(ita_pkg::SUM_MAX);
      if (over) begin
         term_in = neg_ff ? ita_pkg::SUM_MIN : ita_pkg::SUM_MAX;
      end else if (neg_ff) begin
         term_in = ~full_ext[SW-1:0] + 64'd1;
      end else begin
         term_in = full_ext[SW-1:0];
      end
   end

   // one read port over the sums, shared by accumulate and emission
   assign rd_idx = cmd.emit_en ? ita_pkg::elem_src(cmd.emit_idx) : cmd.term_sel;
   assign rd_val = sum_ff[rd_idx];

   always_comb begin
      acc_wide = {rd_val[SW-1], rd_val} + {term_ff[SW-1], term_ff};
      if (acc_wide[SW] != acc_wide[SW-1]) begin
         acc_in = acc_wide[SW] ? ita_pkg::SUM_MIN : ita_pkg::SUM_MAX;
      end else begin
         acc_in = acc_wide[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mag_x_ff <= mag_of(req_port.center_x);
         mag_y_ff <= mag_of(req_port.center_y);
         mag_z_ff <= mag_of(req_port.center_z);
         sgn_x_ff <= req_port.center_x[C-1];
         sgn_y_ff <= req_port.center_y[C-1];
         sgn_z_ff <= req_port.center_z[C-1];
         mass_ff  <= req_port.cell_mass;
         ghost_ff <= req_port.ghost_cell;
         last_ff  <= req_port.last_cell;
      end
      if (cmd.prod_en) begin
         prod_ff[cmd.prod_sel] <= mul_res[PW-1:0];
      end
      if (cmd.term_en) begin
         case (cmd.step)
            ita_pkg::STEP_SEL: begin
               sval_ff <= sval_in;
               neg_ff  <= neg_in;
            end
            ita_pkg::STEP_LO:  lo_ff   <= mul_res[M+C-1:0];
            ita_pkg::STEP_HI:  hi_ff   <= mul_res[M+C-1:0];
            ita_pkg::STEP_SAT: term_ff <= term_in;
            default: ;
         endcase
      end
      if (cmd.emit_en) begin
         rsp_index_ff <= cmd.emit_idx;
         rsp_value_ff <= rd_val;
         rsp_final_ff <= (cmd.emit_idx == 4'(ita_pkg::TENSOR_ELEMS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ita_pkg::SUM_COUNT; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (cmd.capture && req_port.first_cell) begin
         for (int i = 0; i < ita_pkg::SUM_COUNT; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (cmd.term_en && cmd.step == ita_pkg::STEP_ACC) begin
         sum_ff[cmd.term_sel] <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.element_index = rsp_index_ff;
   assign rsp_port.element_value = rsp_value_ff;
   assign rsp_port.final_element = rsp_final_ff;

   assign sts.ghost    = ghost_ff;
   assign sts.last     = last_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_port.ready;

   `ITA_ASSERT_IMPLIES(a_diag_nonneg, clock, reset, 1'b1, !sum_ff[ita_pkg::TERM_XX][SW-1] && !sum_ff[ita_pkg::TERM_YY][SW-1] && !sum_ff[ita_pkg::TERM_ZZ][SW-1], "diagonal sum went negative")
   `ITA_ASSERT_IMPLIES(a_no_overwrite, clock, reset, cmd.emit_en, !rsp_valid_ff || rsp_port.ready, "element overwritten before taken")
   `ITA_ASSERT_NEXT(a_first_clears, clock, reset, cmd.capture && req_port.first_cell, sum_ff[ita_pkg::TERM_XX] == '0 && sum_ff[ita_pkg::TERM_XY] == '0 && sum_ff[ita_pkg::TERM_YZ] == '0, "first cell did not clear sums")

endmodule

// File: design/inertia_tensor_accumulator.sv
// ----------------------------------------------------------------------------
// inertia_tensor_accumulator
// moment of inertia tensor of point masses, accumulated one cell per item
// ----------------------------------------------------------------------------
//
//   channel    dir   payload                                          handshake
//   req_port   in    center_x/y/z, cell_mass, ghost/first/last_cell   valid/ready
//   rsp_port   out   element_index, element_value, final_element      valid/ready
//
// a non-ghost item runs an accept step, 6 coordinate products, then
// 5 steps for each of the six sums (select, two half multiplies, clamp, add);
// a ghost item runs only the accept and the products; all multiplies use the one shared multiplier
// an item flagged last adds the emission of nine elements, which waits while rsp_port stalls;
// the next item is taken while the ninth element still sits in the output register
// reset is synchronous and active high; it zeroes the six sums

module inertia_tensor_accumulator #(
   parameter int COORD_BITS = ita_pkg::COORD_BITS_DEF,
   parameter int MASS_BITS  = ita_pkg::MASS_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ita_req_if.sink   req_port,
   ita_rsp_if.source rsp_port
);

   // command and status between the sequencer and the arithmetic
   ita_pkg::cmd_type cmd;
   ita_pkg::sts_type sts;
   logic             req_ready;

   ita_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // ready comes straight from a controller register, high only when idle
   assign req_port.ready = req_ready;

   ita_datapath #(
      .COORD_BITS (COORD_BITS),
      .MASS_BITS  (MASS_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule
